// File: rtl/hps_pkg.sv
`timescale 1ns / 1ps

package hps_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned TICK_MS = 10;

	typedef enum logic {
		REQ_START = 1'b0,
		REQ_TICK = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		CAUSE_RUNNING = 2'd0,
		CAUSE_SETTLED = 2'd1,
		CAUSE_TIMEOUT = 2'd2,
		CAUSE_IDLE = 2'd3
	} cause_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN = 3'd0,
		REG_INTEG_GAIN = 3'd1,
		REG_DERIV_GAIN = 3'd2,
		REG_ERROR_BAND = 3'd3,
		REG_SPEED_LIMIT = 3'd4
	} cfg_reg_t;

	localparam logic [31:0] PROP_GAIN_RST = 32'd87960930;
	localparam logic [31:0] INTEG_GAIN_RST = 32'd164927;
	localparam logic [31:0] DERIV_GAIN_RST = 32'd46179488;
	localparam logic [15:0] ERROR_BAND_RST = 16'd300;
	localparam logic signed [13:0] SPEED_LIMIT_RST = 14'sd10;

	typedef struct packed {
		logic [31:0] prop;
		logic [31:0] integ;
		logic [31:0] deriv;
	} gains_t;

	typedef struct packed {
		logic [15:0] band;
		logic signed [13:0] speed;
	} limits_t;

	typedef struct packed {
		logic signed [21:0] err;
		logic signed [31:0] isum;
		logic signed [22:0] deriv;
		cause_t cause;
	} work_t;

endpackage

// File: rtl/heading_pid_with_settle.sv
`timescale 1ns / 1ps
// A tick request goes through the queue, then the multiply, sum and saturate stages.
// Throughput: one request per cycle unless out_ready stalls the three-stage pipeline.
// Start requests return nothing and are handled in the front stage only.
// Reset is asynchronous and active low; it clears the move state, the queue and the
// pipeline valids, and loads the default gains, error band and speed limit.
module heading_pid_with_settle #(
	parameter int unsigned QueueDepth = hps_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic req_type,
	input  logic signed [20:0] target_heading,
	input  logic [15:0] time_limit_ms,
	input  logic signed [20:0] heading,
	input  logic signed [13:0] speed_right_front,
	input  logic signed [13:0] speed_right_back,
	input  logic signed [13:0] speed_left_front,
	input  logic signed [13:0] speed_left_back,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [15:0] left_drive,
	output logic signed [15:0] right_drive,
	output logic [1:0] end_cause,
	output logic signed [21:0] heading_error,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [hps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hps_pkg::CFG_DATA_W-1:0] cfg_data
);

	hps_pkg::gains_t gains_q;
	hps_pkg::limits_t limits_q;

	logic q_full;
	logic push;
	hps_pkg::work_t push_data;
	logic pop;
	logic head_valid;
	hps_pkg::work_t head_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.prop <= hps_pkg::PROP_GAIN_RST;
			gains_q.integ <= hps_pkg::INTEG_GAIN_RST;
			gains_q.deriv <= hps_pkg::DERIV_GAIN_RST;
			limits_q.band <= hps_pkg::ERROR_BAND_RST;
			limits_q.speed <= hps_pkg::SPEED_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (hps_pkg::cfg_reg_t'(cfg_index))
				hps_pkg::REG_PROP_GAIN: begin
					gains_q.prop <= cfg_data[31:0];
				end
				hps_pkg::REG_INTEG_GAIN: begin
					gains_q.integ <= cfg_data[31:0];
				end
				hps_pkg::REG_DERIV_GAIN: begin
					gains_q.deriv <= cfg_data[31:0];
				end
				hps_pkg::REG_ERROR_BAND: begin
					limits_q.band <= cfg_data[15:0];
				end
				hps_pkg::REG_SPEED_LIMIT: begin
					limits_q.speed <= cfg_data[13:0];
				end
				default: begin
				end
			endcase
		end
	end

	hps_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.target_heading(target_heading),
		.time_limit_ms(time_limit_ms),
		.heading(heading),
		.speed_right_front(speed_right_front),
		.speed_right_back(speed_right_back),
		.speed_left_front(speed_left_front),
		.speed_left_back(speed_left_back),
		.lim(limits_q),
		.q_full(q_full),
		.push(push),
		.push_data(push_data)
	);

	hps_fifo #(
		.Depth(QueueDepth)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(q_full),
		.pop(pop),
		.head_valid(head_valid),
		.head_data(head_data)
	);

	hps_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.gains(gains_q),
		.head_valid(head_valid),
		.head_data(head_data),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_drive(left_drive),
		.right_drive(right_drive),
		.end_cause(end_cause),
		.heading_error(heading_error)
	);

endmodule

// File: rtl/hps_front.sv
`timescale 1ns / 1ps

module hps_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic req_type,
	input  logic signed [20:0] target_heading,
	input  logic [15:0] time_limit_ms,
	input  logic signed [20:0] heading,
	input  logic signed [13:0] speed_right_front,
	input  logic signed [13:0] speed_right_back,
	input  logic signed [13:0] speed_left_front,
	input  logic signed [13:0] speed_left_back,
	input  hps_pkg::limits_t lim,
	input  logic q_full,
	output logic push,
	output hps_pkg::work_t push_data
);

	logic running_q;
	logic signed [20:0] target_q;
	logic [15:0] limit_q;
	logic [16:0] elapsed_q;
	logic signed [31:0] esum_q;
	logic signed [21:0] lasterr_q;

	logic accept;
	logic is_tick;
	logic signed [21:0] err;
	logic signed [32:0] sum_wide;
	logic signed [31:0] esum_next;
	logic signed [22:0] deriv;
	logic [21:0] aerr;
	logic slow;
	logic settled;
	logic [17:0] elapsed_inc;
	logic [16:0] elapsed_next;
	logic timeout;

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;
	assign is_tick = (hps_pkg::req_t'(req_type) == hps_pkg::REQ_TICK);
	assign push = accept && is_tick;

	always_comb begin
		err = 22'(target_q) - 22'(heading);
		sum_wide = 33'(esum_q) + 33'(err);
		if (sum_wide > 33'sd2147483647) begin
			esum_next = 32'sh7FFFFFFF;
		end else if (sum_wide < -33'sd2147483648) begin
			esum_next = 32'sh80000000;
		end else begin
			esum_next = sum_wide[31:0];
		end
		deriv = 23'(err) - 23'(lasterr_q);
		aerr = err[21] ? 22'(-err) : err;
		slow = (speed_right_front < lim.speed) && (speed_right_back < lim.speed)
			&& (speed_left_front < lim.speed) && (speed_left_back < lim.speed);
		settled = (aerr < {6'd0, lim.band}) && slow;
		elapsed_inc = {1'b0, elapsed_q} + 18'(hps_pkg::TICK_MS);
		elapsed_next = elapsed_inc[17] ? 17'h1FFFF : elapsed_inc[16:0];
		timeout = (elapsed_next >= {1'b0, limit_q});

		if (!running_q) begin
			push_data.err = '0;
			push_data.isum = '0;
			push_data.deriv = '0;
			push_data.cause = hps_pkg::CAUSE_IDLE;
		end else begin
			push_data.err = err;
			push_data.isum = esum_next;
			push_data.deriv = deriv;
			if (settled) begin
				push_data.cause = hps_pkg::CAUSE_SETTLED;
			end else if (timeout) begin
				push_data.cause = hps_pkg::CAUSE_TIMEOUT;
			end else begin
				push_data.cause = hps_pkg::CAUSE_RUNNING;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			target_q <= '0;
			limit_q <= '0;
			elapsed_q <= '0;
			esum_q <= '0;
			lasterr_q <= '0;
		end else if (accept) begin
			if (!is_tick) begin
				target_q <= target_heading;
				limit_q <= time_limit_ms;
				elapsed_q <= '0;
				esum_q <= '0;
				lasterr_q <= '0;
				running_q <= 1'b1;
			end else if (running_q) begin
				esum_q <= esum_next;
				lasterr_q <= err;
				if (settled) begin
					running_q <= 1'b0;
				end else begin
					elapsed_q <= elapsed_next;
					if (timeout) begin
						running_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

// File: rtl/hps_fifo.sv
`timescale 1ns / 1ps

module hps_fifo #(
	parameter int unsigned Depth = hps_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  hps_pkg::work_t push_data,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output hps_pkg::work_t head_data
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	hps_pkg::work_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CntW'(Depth));
	assign head_valid = (count_q != '0);
	assign head_data = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue count beyond depth");

endmodule

// File: rtl/hps_back.sv
`timescale 1ns / 1ps

module hps_back (
	input  logic clk,
	input  logic arst_n,
	input  hps_pkg::gains_t gains,
	input  logic head_valid,
	input  hps_pkg::work_t head_data,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [15:0] left_drive,
	output logic signed [15:0] right_drive,
	output logic [1:0] end_cause,
	output logic signed [21:0] heading_error
);

	localparam logic signed [64:0] IMax = 65'sd1 <<< 60;
	localparam logic signed [38:0] DriveMax = 39'sd32767;

	logic advance;

	logic valid_s1;
	logic signed [54:0] pterm_s1;
	logic signed [64:0] iterm_s1;
	logic signed [55:0] dterm_s1;
	logic signed [21:0] err_s1;
	hps_pkg::cause_t cause_s1;

	logic valid_s2;
	logic signed [62:0] sum_s2;
	logic signed [21:0] err_s2;
	hps_pkg::cause_t cause_s2;

	logic valid_s3;
	logic signed [15:0] drive_s3;
	logic signed [21:0] err_s3;
	hps_pkg::cause_t cause_s3;

	logic signed [61:0] iclamp;
	logic signed [38:0] shifted;
	logic signed [15:0] drive_sat;

	assign advance = !valid_s3 || out_ready;
	assign pop = advance;

	always_comb begin
		if (iterm_s1 > IMax) begin
			iclamp = 62'(IMax);
		end else if (iterm_s1 < -IMax) begin
			iclamp = 62'(-IMax);
		end else begin
			iclamp = iterm_s1[61:0];
		end
		shifted = sum_s2[62:24];
		if (shifted > DriveMax) begin
			drive_sat = 16'sd32767;
		end else if (shifted < -DriveMax) begin
			drive_sat = -16'sd32767;
		end else begin
			drive_sat = shifted[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pterm_s1 <= 55'($signed({1'b0, gains.prop})) * 55'(head_data.err);
			iterm_s1 <= 65'($signed({1'b0, gains.integ})) * 65'(head_data.isum);
			dterm_s1 <= 56'($signed({1'b0, gains.deriv})) * 56'(head_data.deriv);
			err_s1 <= head_data.err;
			cause_s1 <= head_data.cause;
			sum_s2 <= 63'(pterm_s1) + 63'(dterm_s1) + 63'(iclamp);
			err_s2 <= err_s1;
			cause_s2 <= cause_s1;
			drive_s3 <= drive_sat;
			err_s3 <= err_s2;
			cause_s3 <= cause_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= head_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign out_valid = valid_s3;
	assign left_drive = drive_s3;
	assign right_drive = -drive_s3;
	assign end_cause = cause_s3;
	assign heading_error = err_s3;

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && end_cause == hps_pkg::CAUSE_IDLE) |-> (left_drive == 16'sd0
			&& heading_error == 22'sd0))
		else $error("idle result with nonzero drive or error");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (left_drive != 16'sh8000))
		else $error("drive outside saturation range");

	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !out_ready) |=> (valid_s3 && $stable(drive_s3)
			&& $stable(cause_s3)))
		else $error("stalled result changed");

endmodule

// File: tb/sv/heading_pid_with_settle_test.sv
`timescale 1ns / 1ps

import hps_pkg::*;

localparam longint ISUM_HI = 64'sd2147483647;
localparam longint ISUM_LO = -64'sd2147483648;
localparam longint ITERM_CAP = 64'sd1152921504606846976;
localparam longint DRIVE_CAP = 64'sd32767;
localparam longint ELAPSED_MAX = 64'sd131071;

typedef struct packed {
	req_t kind;
	logic signed [20:0] target;
	logic [15:0] limit_ms;
	logic signed [20:0] heading;
	logic signed [13:0] rf;
	logic signed [13:0] rb;
	logic signed [13:0] lf;
	logic signed [13:0] lb;
} move_req_t;

typedef struct packed {
	logic signed [15:0] left;
	logic signed [15:0] right;
	cause_t cause;
	logic signed [21:0] err;
} drive_out_t;

class heading_scoreboard;
	logic [31:0] kp;
	logic [31:0] ki;
	logic [31:0] kd;
	logic [15:0] band;
	logic signed [13:0] speed_lim;
	bit armed;
	logic signed [20:0] target;
	logic [15:0] limit_ms;
	logic [16:0] elapsed;
	logic signed [31:0] isum;
	logic signed [21:0] last_err;
	drive_out_t expected_drives[$];
	int errors;
	int checked;
	int settled;
	int timeouts;
	int idles;
	int unsigned requests;

	function new();
		kp = PROP_GAIN_RST;
		ki = INTEG_GAIN_RST;
		kd = DERIV_GAIN_RST;
		band = ERROR_BAND_RST;
		speed_lim = SPEED_LIMIT_RST;
		armed = 1'b0;
		target = '0;
		limit_ms = '0;
		elapsed = '0;
		isum = '0;
		last_err = '0;
	endfunction

	function void set_reg(cfg_reg_t idx, logic [31:0] v);
		case (idx)
			REG_PROP_GAIN: kp = v;
			REG_INTEG_GAIN: ki = v;
			REG_DERIV_GAIN: kd = v;
			REG_ERROR_BAND: band = v[15:0];
			REG_SPEED_LIMIT: speed_lim = v[13:0];
			default: ;
		endcase
	endfunction

	// A start request only rearms the move; every tick request yields one drive result.
	function void note_request(move_req_t r);
		longint err;
		longint acc;
		longint pterm;
		longint iterm;
		longint dterm;
		longint drv;
		longint aerr;
		longint ms;
		bit slow;
		drive_out_t res;
		requests++;
		if (r.kind == REQ_START) begin
			target = r.target;
			limit_ms = r.limit_ms;
			elapsed = '0;
			isum = '0;
			last_err = '0;
			armed = 1'b1;
			return;
		end
		res = '0;
		res.cause = CAUSE_IDLE;
		if (armed) begin
			err = longint'(target) - longint'(r.heading);
			acc = longint'(isum) + err;
			if (acc > ISUM_HI) acc = ISUM_HI;
			if (acc < ISUM_LO) acc = ISUM_LO;
			isum = acc[31:0];
			dterm = longint'({32'd0, kd}) * (err - longint'(last_err));
			last_err = err[21:0];
			pterm = longint'({32'd0, kp}) * err;
			iterm = longint'({32'd0, ki}) * longint'(isum);
			if (iterm > ITERM_CAP) iterm = ITERM_CAP;
			if (iterm < -ITERM_CAP) iterm = -ITERM_CAP;
			drv = (pterm + dterm + iterm) >>> 24;
			if (drv > DRIVE_CAP) drv = DRIVE_CAP;
			if (drv < -DRIVE_CAP) drv = -DRIVE_CAP;
			res.left = drv[15:0];
			drv = -drv;
			res.right = drv[15:0];
			res.err = err[21:0];
			slow = (r.rf < speed_lim) && (r.rb < speed_lim) && (r.lf < speed_lim)
				&& (r.lb < speed_lim);
			aerr = (err < 0) ? -err : err;
			if (aerr < longint'({48'd0, band}) && slow) begin
				res.cause = CAUSE_SETTLED;
				armed = 1'b0;
			end else begin
				ms = longint'({47'd0, elapsed}) + TICK_MS;
				if (ms > ELAPSED_MAX) ms = ELAPSED_MAX;
				elapsed = ms[16:0];
				if (ms >= longint'({48'd0, limit_ms})) begin
					res.cause = CAUSE_TIMEOUT;
					armed = 1'b0;
				end else begin
					res.cause = CAUSE_RUNNING;
				end
			end
		end
		expected_drives.push_back(res);
	endfunction

	function void compare_field(string name, longint want, longint got);
		if (want != got) begin
			errors++;
			if (errors <= 30)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	function void check_result(drive_out_t got);
		drive_out_t want;
		if (expected_drives.size() == 0) begin
			errors++;
			if (errors <= 30)
				$display("%0t: unexpected drive result, expected none, got %0d/%0d/%0d/%0d",
					$time, got.left, got.right, got.cause, got.err);
			return;
		end
		want = expected_drives.pop_front();
		checked++;
		case (want.cause)
			CAUSE_SETTLED: settled++;
			CAUSE_TIMEOUT: timeouts++;
			CAUSE_IDLE: idles++;
			default: ;
		endcase
		compare_field("left_drive", want.left, got.left);
		compare_field("right_drive", want.right, got.right);
		compare_field("end_cause", want.cause, got.cause);
		compare_field("heading_error", want.err, got.err);
	endfunction
endclass

module heading_pid_with_settle_test;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic req_type = 1'b0;
	logic signed [20:0] target_heading = '0;
	logic [15:0] time_limit_ms = '0;
	logic signed [20:0] heading = '0;
	logic signed [13:0] speed_right_front = '0;
	logic signed [13:0] speed_right_back = '0;
	logic signed [13:0] speed_left_front = '0;
	logic signed [13:0] speed_left_back = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] left_drive;
	logic signed [15:0] right_drive;
	logic [1:0] end_cause;
	logic signed [21:0] heading_error;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int send_idle_pct = 8;
	int stall_pct = 84;
	heading_scoreboard sb;

	heading_pid_with_settle dut (.*);

	initial forever #5 clk = ~clk;

	initial forever begin
		@(posedge clk);
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		drive_out_t got;
		bit fire;
		forever begin
			@(negedge clk);
			fire = out_valid && out_ready;
			got.left = left_drive;
			got.right = right_drive;
			got.cause = cause_t'(end_cause);
			got.err = heading_error;
			@(posedge clk);
			if (fire) sb.check_result(got);
		end
	end

	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic signed [13:0] rand_speed();
		int v;
		v = int'($urandom_range(12000)) - 6000;
		return 14'(v);
	endfunction

	function automatic logic signed [13:0] slow_speed();
		int lim;
		lim = int'(sb.speed_lim);
		if (lim <= -6000) return -14'sd6000;
		return 14'(int'($urandom_range(lim + 5999)) - 6000);
	endfunction

	function automatic logic signed [20:0] clamp_heading(longint v);
		if (v > 1048575) v = 1048575;
		if (v < -1048576) v = -1048576;
		return v[20:0];
	endfunction

	function automatic move_req_t random_req();
		move_req_t r;
		r.kind = req_t'($urandom_range(1));
		r.target = 21'($urandom());
		r.limit_ms = 16'($urandom());
		r.heading = 21'($urandom());
		r.rf = rand_speed();
		r.rb = rand_speed();
		r.lf = rand_speed();
		r.lb = rand_speed();
		return r;
	endfunction

	task automatic send_item(move_req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.kind;
		target_heading <= r.target;
		time_limit_ms <= r.limit_ms;
		heading <= r.heading;
		speed_right_front <= r.rf;
		speed_right_back <= r.rb;
		speed_left_front <= r.lf;
		speed_left_back <= r.lb;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		sb.note_request(r);
	endtask

	task automatic send_start(longint tgt, longint ms);
		move_req_t r;
		r = random_req();
		r.kind = REQ_START;
		r.target = tgt[20:0];
		r.limit_ms = ms[15:0];
		send_item(r);
	endtask

	task automatic send_tick(longint hd, int rf, int rb, int lf, int lb);
		move_req_t r;
		r = random_req();
		r.kind = REQ_TICK;
		r.heading = hd[20:0];
		r.rf = 14'(rf);
		r.rb = 14'(rb);
		r.lf = 14'(lf);
		r.lb = 14'(lb);
		send_item(r);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		sb.set_reg(idx, v);
	endtask

	task automatic program_regs(logic [31:0] p, logic [31:0] i, logic [31:0] d,
		logic [15:0] b, logic signed [13:0] s);
		write_reg(REG_PROP_GAIN, p);
		write_reg(REG_INTEG_GAIN, i);
		write_reg(REG_DERIV_GAIN, d);
		write_reg(REG_ERROR_BAND, {16'd0, b});
		write_reg(REG_SPEED_LIMIT, {{18{s[13]}}, s});
		cfg_valid <= 1'b0;
	endtask

	// Start requests can still be in the front stage when the last drive result leaves.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_drives.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// A move converges on its target so that settling, band edges and timeouts all occur.
	task automatic random_move();
		move_req_t r;
		longint tgt;
		int ms;
		int span;
		int off;
		int band;
		int n;
		if ($urandom_range(1) == 0)
			tgt = longint'($signed(21'($urandom())));
		else
			tgt = longint'(int'($urandom_range(72000)) - 36000);
		case ($urandom_range(3))
			0: ms = $urandom_range(60);
			1: ms = $urandom_range(400);
			2: ms = $urandom_range(3000);
			default: ms = $urandom_range(65535);
		endcase
		send_start(tgt, ms);
		band = int'(sb.band);
		span = ($urandom_range(3) == 0) ? 1500000 : band * 4 + 50;
		n = $urandom_range(1, 25);
		repeat (n) begin
			r = random_req();
			r.kind = REQ_TICK;
			off = int'($urandom_range(2 * span)) - span;
			if ($urandom_range(7) == 0) off = ($urandom_range(1) == 0) ? band : 1 - band;
			r.heading = clamp_heading(tgt + off);
			if ($urandom_range(1) == 0) begin
				r.rf = slow_speed();
				r.rb = slow_speed();
				r.lf = slow_speed();
				r.lb = slow_speed();
			end else if ($urandom_range(2) == 0) begin
				r.lb = slow_speed();
			end
			send_item(r);
			span = span / 2 + 1;
		end
	endtask

	// Full-scale error held long enough to drive the integral into its clamp.
	task automatic saturate_integral(bit negative);
		move_req_t r;
		send_start(negative ? -64'sd1048576 : 64'sd1048575, 65535);
		repeat (1030) begin
			r = random_req();
			r.kind = REQ_TICK;
			r.heading = negative ? 21'sh0FFFFF : 21'sh100000;
			send_item(r);
		end
	endtask

	initial begin
		int ph;
		int unsigned mark;
		bit paused;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_tick(0, 0, 0, 0, 0);
		send_start(0, 0);
		send_tick(0, 6000, 6000, 6000, 6000);
		send_tick(-1048576, -6000, -6000, -6000, -6000);
		send_start(1048575, 65535);
		send_tick(-1048576, -6000, -6000, -6000, -6000);
		send_tick(1048575, 6000, -6000, 6000, -6000);
		send_start(-1048576, 30);
		send_tick(1048575, 0, 0, 0, 0);
		send_tick(-1048571, 9, 9, 9, 9);
		send_start(100, 1000);
		send_start(-100, 20);
		send_tick(199, 9, -6000, 0, 9);
		send_start(500, 20);
		send_tick(200, 0, 0, 0, 0);
		send_tick(500, 0, 0, 0, 10);
		send_start(-2000, 65535);
		send_tick(-1700, 0, 0, 0, 0);
		send_tick(-2299, 9, 9, 9, -1);
		drain();

		for (ph = 1; ph <= 6; ph++) begin
			if (ph >= 5) begin
				send_idle_pct = 0;
				stall_pct = 0;
			end else if (ph >= 3) begin
				send_idle_pct = 84;
				stall_pct = 8;
			end
			case (ph)
				1: program_regs($urandom_range(1 << 28), $urandom_range(1 << 20),
					$urandom_range(1 << 27), 16'($urandom_range(50, 2000)),
					14'($urandom_range(200)));
				2: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
					14'sd6000);
				3: program_regs(32'd0, 32'd0, 32'd0, 16'd0, -14'sd6000);
				4: program_regs($urandom_range(255), $urandom_range(1, 3),
					$urandom_range(255), 16'($urandom()), rand_speed());
				5: program_regs($urandom(), 32'hFFFF_FFFF, $urandom(), 16'($urandom()),
					rand_speed());
				default: program_regs(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST,
					ERROR_BAND_RST, SPEED_LIMIT_RST);
			endcase
			if (ph == 4) begin
				saturate_integral(1'($urandom_range(1)));
			end
			mark = sb.requests;
			paused = 1'b0;
			while (sb.requests - mark < 135) begin
				if (!paused && sb.requests - mark >= 68) begin
					drain();
					paused = 1'b1;
				end
				if ($urandom_range(9) < 8)
					random_move();
				else
					send_item(random_req());
			end
			drain();
		end

		$display("Run covered %0d requests and %0d drive results:",
			sb.requests, sb.checked);
		$display("%0d settled, %0d timed out, %0d idle; gains ran from zero to full scale.",
			sb.settled, sb.timeouts, sb.idles);
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
